// ===== design/idq_pkg.sv =====
// Shared types and codes for the indexed deque engine.
package idq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_READ,
    S_READ_DONE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_REPLY
  } state_t;

  // logical index register load
  typedef enum logic [2:0] {
    K_HOLD,
    K_ZERO,
    K_POS,
    K_COUNT,
    K_COUNT_M1,
    K_LAST,
    K_INC
  } k_sel_t;

  typedef enum logic [1:0] {
    H_HOLD,
    H_INC,
    H_DEC,
    H_ZERO
  } head_op_t;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INC,
    C_DEC,
    C_ZERO
  } count_op_t;

  typedef struct packed {
    logic      latch;       // take the input item
    k_sel_t    k_sel;
    logic      rd_next;     // read slot(k+1) instead of slot(k)
    logic      mem_we;      // write slot(k)
    logic      wr_from_mem; // write data is the last read word
    head_op_t  head_op;
    count_op_t count_op;
    logic      res_load;
    status_t   res_status;
    logic      res_val_mem; // value from the last read word
    logic      res_idx_k;   // found index from k
    logic      publish;     // move result into the output register
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic pos_oor;  // position at or beyond count
    logic k_last;   // k+1 at or beyond count
    logic k_end;    // k at or beyond count
    logic match;    // last read word equals search value
    logic out_free;
  } sts_t;

endpackage

// ===== design/indexed_deque_engine.sv =====
// Refused or failed items and clear load their result at decode; pushes write the new slot, pops and reads
// fetch the slot and then load it; find reads and compares each index from zero until a match or the end;
// remove walks the later entries one by one through the single-read-port store, shifting each toward the front.
// One item at a time: the next item is taken the cycle after its result enters the output
// register, even while that result still waits on m_tready.
// Synchronous reset clears head, occupancy, output valid and the sequencer; stored words are kept.
module indexed_deque_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // data_in[31:0], position[39:32]
  input  logic [2:0]  s_tuser,  // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // value_out[31:0], found_index[35:32], entry_count[40:36], zero
  output logic [2:0]  m_tuser   // status[2:0]
);

  idq_pkg::cmd_t cmd;
  idq_pkg::sts_t sts;

  idq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  idq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== design/idq_ctrl.sv =====
// Sequencer for the indexed deque engine: decodes each item and steps the datapath.
module idq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  idq_pkg::sts_t sts,
  output idq_pkg::cmd_t cmd
);

  idq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      idq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = idq_pkg::S_EXEC;
        end
      end
      idq_pkg::S_EXEC: begin
        state_next = idq_pkg::S_REPLY;
        unique case (sts.op) inside
          idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_PUSH_BACK: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = idq_pkg::ST_FULL;
            end else begin
              // slot(DEPTH-1) is the ring place just before the head
              cmd.k_sel  = (sts.op == idq_pkg::OP_PUSH_FRONT) ? idq_pkg::K_LAST
                                                               : idq_pkg::K_COUNT;
              state_next = idq_pkg::S_PUSH;
            end
          end
          idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_BACK, idq_pkg::OP_READ,
          idq_pkg::OP_REMOVE: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = idq_pkg::ST_EMPTY;
            end else if (sts.op == idq_pkg::OP_POP_FRONT) begin
              cmd.k_sel  = idq_pkg::K_ZERO;
              state_next = idq_pkg::S_READ;
            end else if (sts.op == idq_pkg::OP_POP_BACK) begin
              cmd.k_sel  = idq_pkg::K_COUNT_M1;
              state_next = idq_pkg::S_READ;
            end else if (sts.pos_oor) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = idq_pkg::ST_RANGE;
            end else begin
              cmd.k_sel  = idq_pkg::K_POS;
              state_next = (sts.op == idq_pkg::OP_READ) ? idq_pkg::S_READ
                                                        : idq_pkg::S_SHIFT_RD;
            end
          end
          idq_pkg::OP_FIND: begin
            cmd.k_sel  = idq_pkg::K_ZERO;
            state_next = idq_pkg::S_FIND_RD;
          end
          idq_pkg::OP_CLEAR: begin
            cmd.head_op    = idq_pkg::H_ZERO;
            cmd.count_op   = idq_pkg::C_ZERO;
            cmd.res_load   = 1'b1;
            cmd.res_status = idq_pkg::ST_OK;
          end
          default: ;
        endcase
      end
      idq_pkg::S_PUSH: begin
        cmd.mem_we     = 1'b1;
        cmd.head_op    = (sts.op == idq_pkg::OP_PUSH_FRONT) ? idq_pkg::H_DEC
                                                             : idq_pkg::H_HOLD;
        cmd.count_op   = idq_pkg::C_INC;
        cmd.res_load   = 1'b1;
        cmd.res_status = idq_pkg::ST_OK;
        state_next     = idq_pkg::S_REPLY;
      end
      idq_pkg::S_READ: begin
        // slot(k) is fetched at this edge; pointers may move at the same edge
        if (sts.op == idq_pkg::OP_POP_FRONT) begin
          cmd.head_op  = idq_pkg::H_INC;
          cmd.count_op = idq_pkg::C_DEC;
        end else if (sts.op == idq_pkg::OP_POP_BACK) begin
          cmd.count_op = idq_pkg::C_DEC;
        end
        state_next = idq_pkg::S_READ_DONE;
      end
      idq_pkg::S_READ_DONE: begin
        cmd.res_load    = 1'b1;
        cmd.res_status  = idq_pkg::ST_OK;
        cmd.res_val_mem = 1'b1;
        state_next      = idq_pkg::S_REPLY;
      end
      idq_pkg::S_SHIFT_RD: begin
        if (sts.k_last) begin
          cmd.count_op   = idq_pkg::C_DEC;
          cmd.res_load   = 1'b1;
          cmd.res_status = idq_pkg::ST_OK;
          state_next     = idq_pkg::S_REPLY;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = idq_pkg::S_SHIFT_WR;
        end
      end
      idq_pkg::S_SHIFT_WR: begin
        cmd.mem_we      = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.k_sel       = idq_pkg::K_INC;
        state_next      = idq_pkg::S_SHIFT_RD;
      end
      idq_pkg::S_FIND_RD: begin
        if (sts.k_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = idq_pkg::ST_NOT_FOUND;
          state_next     = idq_pkg::S_REPLY;
        end else begin
          state_next = idq_pkg::S_FIND_CMP;
        end
      end
      idq_pkg::S_FIND_CMP: begin
        if (sts.match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = idq_pkg::ST_OK;
          cmd.res_idx_k  = 1'b1;
          state_next     = idq_pkg::S_REPLY;
        end else begin
          cmd.k_sel  = idq_pkg::K_INC;
          state_next = idq_pkg::S_FIND_RD;
        end
      end
      idq_pkg::S_REPLY: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = idq_pkg::S_IDLE;
        end
      end
      default: state_next = idq_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/idq_datapath.sv =====
// Ring store, pointers, walk index and result/output registers of the deque engine.
module idq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [39:0]   s_tdata,
  input  logic [2:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [47:0]   m_tdata,
  output logic [2:0]    m_tuser,
  input  idq_pkg::cmd_t cmd,
  output idq_pkg::sts_t sts
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int PXW = CW + 8;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  idq_pkg::op_t          op;
  logic [DATA_WIDTH-1:0] data;
  logic [7:0]            pos;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         k, k_next;

  logic [31:0]           res_value;
  logic [3:0]            res_idx;
  idq_pkg::status_t      res_status;

  logic [31:0]           out_value;
  logic [3:0]            out_idx;
  logic [4:0]            out_count;
  idq_pkg::status_t      out_status;

  logic [CW-1:0]         k_plus;
  logic [SW-1:0]         sum_k, sum_k1;
  logic [AW-1:0]         slot_k, slot_k1;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [PXW-1:0]        pos_ext;

  // ring slot of logical index: head + idx, wrapped once
  assign k_plus = k + CW'(1);
  always_comb begin
    sum_k  = SW'(head) + SW'(k);
    sum_k1 = SW'(head) + SW'(k_plus);
    if (sum_k >= SW'(DEPTH)) sum_k = sum_k - SW'(DEPTH);
    if (sum_k1 >= SW'(DEPTH)) sum_k1 = sum_k1 - SW'(DEPTH);
  end
  assign slot_k  = sum_k[AW-1:0];
  assign slot_k1 = sum_k1[AW-1:0];
  assign raddr   = cmd.rd_next ? slot_k1 : slot_k;
  assign wdata   = cmd.wr_from_mem ? rdata : data;
  assign pos_ext = PXW'(pos);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[slot_k] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    case (cmd.k_sel)
      idq_pkg::K_ZERO:     k_next = '0;
      idq_pkg::K_POS:      k_next = pos_ext[CW-1:0];
      idq_pkg::K_COUNT:    k_next = count;
      idq_pkg::K_COUNT_M1: k_next = count - CW'(1);
      idq_pkg::K_LAST:     k_next = CW'(DEPTH - 1);
      idq_pkg::K_INC:      k_next = k_plus;
      default:             k_next = k;
    endcase
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    if (cmd.latch) begin
      op   <= idq_pkg::op_t'(s_tuser);
      data <= DATA_WIDTH'(s_tdata[31:0]);
      pos  <= s_tdata[39:32];
    end
    if (cmd.res_load) begin
      res_value  <= cmd.res_val_mem ? 32'(rdata) : 32'd0;
      res_idx    <= cmd.res_idx_k ? 4'(k) : 4'd0;
      res_status <= cmd.res_status;
    end
    if (cmd.publish) begin
      out_value  <= res_value;
      out_idx    <= res_idx;
      out_count  <= 5'(count);
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (cmd.head_op)
        idq_pkg::H_INC:  head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        idq_pkg::H_DEC:  head <= (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
        idq_pkg::H_ZERO: head <= '0;
        default:         head <= head;
      endcase
      case (cmd.count_op)
        idq_pkg::C_INC:  count <= count + CW'(1);
        idq_pkg::C_DEC:  count <= count - CW'(1);
        idq_pkg::C_ZERO: count <= '0;
        default:         count <= count;
      endcase
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sts.op       = op;
  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CW'(DEPTH));
  assign sts.pos_oor  = (pos_ext >= PXW'(count));
  assign sts.k_last   = (SW'(k) + SW'(1) >= SW'(count));
  assign sts.k_end    = (k >= count);
  assign sts.match    = (rdata == data);
  assign sts.out_free = !m_tvalid || m_tready;

  assign m_tdata = {7'd0, out_count, out_idx, out_value};
  assign m_tuser = out_status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_tvalid || m_tready))
    else $error("result overwrote a waiting output item");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.count_op == idq_pkg::C_INC |=> count == $past(count) + CW'(1))
    else $error("push did not grow occupancy");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_we && !cmd.wr_from_mem) |-> count < CW'(DEPTH))
    else $error("push write into a full store");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> slot_k < AW'(DEPTH - 1) || slot_k == AW'(DEPTH - 1))
    else $error("write slot outside ring");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for indexed_deque_engine: directed table, then random deque traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 40;   // longest walk is find with no match on a full store
  localparam int HOLD_AT     = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PER_PHASE = 660;

  typedef struct packed {
    logic [31:0]      value;
    logic [3:0]       idx;
    logic [4:0]       count;
    idq_pkg::status_t status;
  } deq_result_t;

  typedef struct packed {
    idq_pkg::op_t op;
    logic [31:0]  data;
    logic [7:0]   pos;
    int           reps;
    bit           typed;
    deq_result_t  exp;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_in[31:0], position[39:32]
  logic [2:0]  s_tuser;   // operation[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // value_out[31:0], found_index[35:32], entry_count[40:36], zero
  logic [2:0]  m_tuser;   // status[2:0]

  indexed_deque_engine #(.DEPTH(DEPTH), .DATA_WIDTH(32)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow deque state
  logic [31:0] q_store [DEPTH];
  logic [3:0]  q_head;
  logic [4:0]  q_count;
  bit          filling;

  deq_result_t expected_results [$];
  int          err_count;
  int          n_checked;
  int          op_seen [8];
  int          status_seen [8];
  int          src_idle_pct;
  int          snk_idle_pct;
  int          rx_seen;
  int          hold_left;
  bit          hold_done;
  int          stall_cycles;
  deq_result_t exp_r;
  stim_row_t   dir_rows [26];

  function automatic logic [3:0] slot(input int k);
    return q_head + k[3:0];
  endfunction

  task automatic predict(input idq_pkg::op_t op, input logic [31:0] d, input logic [7:0] p,
                         output deq_result_t r);
    int  k;
    bit  hit;
    r = '0;
    r.status = idq_pkg::ST_OK;
    case (op) inside
      idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_PUSH_BACK: begin
        if (q_count == DEPTH) begin
          r.status = idq_pkg::ST_FULL;
        end else if (op == idq_pkg::OP_PUSH_FRONT) begin
          q_head = q_head - 4'd1;
          q_store[q_head] = d;
          q_count++;
        end else begin
          q_store[slot(int'(q_count))] = d;
          q_count++;
        end
      end
      idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_BACK: begin
        if (q_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else if (op == idq_pkg::OP_POP_FRONT) begin
          r.value = q_store[q_head];
          q_head = q_head + 4'd1;
          q_count--;
        end else begin
          r.value = q_store[slot(int'(q_count) - 1)];
          q_count--;
        end
      end
      idq_pkg::OP_READ: begin
        if (q_count == 0) r.status = idq_pkg::ST_EMPTY;
        else if (p >= q_count) r.status = idq_pkg::ST_RANGE;
        else r.value = q_store[slot(int'(p))];
      end
      idq_pkg::OP_REMOVE: begin
        if (q_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else if (p >= q_count) begin
          r.status = idq_pkg::ST_RANGE;
        end else begin
          // later entries slide one place toward the front
          for (k = int'(p); k + 1 < int'(q_count); k++) q_store[slot(k)] = q_store[slot(k + 1)];
          q_count--;
        end
      end
      idq_pkg::OP_FIND: begin
        hit = 1'b0;
        r.status = idq_pkg::ST_NOT_FOUND;
        for (k = 0; k < int'(q_count); k++) begin
          if (!hit && q_store[slot(k)] == d) begin
            hit = 1'b1;
            r.idx = k[3:0];
            r.status = idq_pkg::ST_OK;
          end
        end
      end
      default: begin
        q_count = '0;
        q_head = '0;
      end
    endcase
    r.count = q_count;
  endtask

  task automatic offer(input idq_pkg::op_t op, input logic [31:0] d, input logic [7:0] p,
                       input bit typed, input deq_result_t typed_exp);
    deq_result_t r;
    int          gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, d};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(op, d, p, r);
    op_seen[op]++;
    status_seen[r.status]++;
    expected_results.insert(expected_results.size(), typed ? typed_exp : r);
  endtask

  // Mostly well-formed traffic that swings between filling up and draining.
  task automatic pick_item(output idq_pkg::op_t op, output logic [31:0] d,
                           output logic [7:0] p);
    int roll;
    int sel;
    if (q_count == DEPTH && $urandom_range(4) == 0) filling = 1'b0;
    if (q_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < 2) op = idq_pkg::OP_CLEAR;
    else if (filling) begin
      if (roll < 35) op = idq_pkg::OP_PUSH_BACK;
      else if (roll < 62) op = idq_pkg::OP_PUSH_FRONT;
      else if (roll < 70) op = idq_pkg::OP_POP_FRONT;
      else if (roll < 76) op = idq_pkg::OP_POP_BACK;
      else if (roll < 84) op = idq_pkg::OP_READ;
      else if (roll < 90) op = idq_pkg::OP_REMOVE;
      else op = idq_pkg::OP_FIND;
    end else begin
      if (roll < 12) op = idq_pkg::OP_PUSH_BACK;
      else if (roll < 20) op = idq_pkg::OP_PUSH_FRONT;
      else if (roll < 42) op = idq_pkg::OP_POP_FRONT;
      else if (roll < 60) op = idq_pkg::OP_POP_BACK;
      else if (roll < 70) op = idq_pkg::OP_READ;
      else if (roll < 84) op = idq_pkg::OP_REMOVE;
      else op = idq_pkg::OP_FIND;
    end
    sel = $urandom_range(9);
    if (sel == 0) d = '0;
    else if (sel == 1) d = '1;
    else if (sel < 4) d = $urandom_range(3);   // small values make duplicates for find
    else d = $urandom;
    if (op == idq_pkg::OP_FIND && q_count > 0 && $urandom_range(9) < 6)
      d = q_store[slot(int'($urandom_range(int'(q_count) - 1)))];
    sel = $urandom_range(9);
    if (q_count > 0 && sel < 8) p = 8'($urandom_range(int'(q_count) - 1));
    else if (sel == 8) p = 8'(q_count);
    else p = 8'($urandom_range(255));
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
    if (g !== e) begin
      $error("%s mismatch: expected %h, got %h", name, e, g);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected item: value_out %h status %0d", m_tdata[31:0], m_tuser);
        err_count++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        check_field("value_out", exp_r.value, m_tdata[31:0]);
        check_field("found_index", 32'(exp_r.idx), 32'(m_tdata[35:32]));
        check_field("entry_count", 32'(exp_r.count), 32'(m_tdata[40:36]));
        check_field("status", 32'(exp_r.status), 32'(m_tuser));
        n_checked++;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off so the engine backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_seen++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    idq_pkg::op_t op;
    logic [31:0]  d;
    logic [7:0]   p;
    int           i;
    int           r;
    int           ph;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    q_head = '0;
    q_count = '0;
    filling = 1'b1;
    err_count = 0;
    n_checked = 0;
    rx_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_cycles = 0;
    src_idle_pct = 27;
    snk_idle_pct = 71;
    for (i = 0; i < 8; i++) begin
      op_seen[i] = 0;
      status_seen[i] = 0;
    end
    for (i = 0; i < DEPTH; i++) q_store[i] = '0;

    //  op                      data          pos   reps typed  value  idx   count  status
    dir_rows = '{
      '{idq_pkg::OP_POP_FRONT,  32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_EMPTY}},
      '{idq_pkg::OP_POP_BACK,   32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_EMPTY}},
      '{idq_pkg::OP_READ,       32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_EMPTY}},
      '{idq_pkg::OP_REMOVE,     32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_EMPTY}},
      '{idq_pkg::OP_FIND,       32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_NOT_FOUND}},
      '{idq_pkg::OP_CLEAR,      32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_OK}},
      '{idq_pkg::OP_PUSH_BACK,  32'hFFFFFFFF, 8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd1,  idq_pkg::ST_OK}},
      '{idq_pkg::OP_PUSH_FRONT, 32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd2,  idq_pkg::ST_OK}},
      '{idq_pkg::OP_READ,       32'h0,        8'd255, 1, 1,
        '{32'h0, 4'd0, 5'd2,  idq_pkg::ST_RANGE}},
      '{idq_pkg::OP_READ,       32'h0,        8'd2,   1, 1,
        '{32'h0, 4'd0, 5'd2,  idq_pkg::ST_RANGE}},
      '{idq_pkg::OP_REMOVE,     32'h0,        8'd2,   1, 1,
        '{32'h0, 4'd0, 5'd2,  idq_pkg::ST_RANGE}},
      '{idq_pkg::OP_READ,       32'h0,        8'd0,   1, 0, '0},
      '{idq_pkg::OP_READ,       32'h0,        8'd1,   1, 0, '0},
      '{idq_pkg::OP_FIND,       32'hFFFFFFFF, 8'd0,   1, 0, '0},
      '{idq_pkg::OP_FIND,       32'h5A5A5A5A, 8'd0,   1, 0, '0},
      '{idq_pkg::OP_REMOVE,     32'h0,        8'd0,   1, 0, '0},
      '{idq_pkg::OP_POP_BACK,   32'h0,        8'd0,   1, 0, '0},
      '{idq_pkg::OP_POP_FRONT,  32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_EMPTY}},
      '{idq_pkg::OP_PUSH_BACK,  32'h80000001, 8'd0,  16, 0, '0},
      '{idq_pkg::OP_PUSH_FRONT, 32'h1,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd16, idq_pkg::ST_FULL}},
      '{idq_pkg::OP_PUSH_BACK,  32'h2,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd16, idq_pkg::ST_FULL}},
      '{idq_pkg::OP_FIND,       32'h8000000E, 8'd0,   1, 0, '0},
      '{idq_pkg::OP_REMOVE,     32'h0,        8'd15,  1, 0, '0},
      '{idq_pkg::OP_REMOVE,     32'h0,        8'd3,   1, 0, '0},
      '{idq_pkg::OP_POP_FRONT,  32'h0,        8'd0,   1, 0, '0},
      '{idq_pkg::OP_CLEAR,      32'h0,        8'd0,   1, 1,
        '{32'h0, 4'd0, 5'd0,  idq_pkg::ST_OK}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n]) begin
      for (r = 0; r < dir_rows[n].reps; r++)
        offer(dir_rows[n].op, dir_rows[n].data ^ r, dir_rows[n].pos,
              dir_rows[n].typed, dir_rows[n].exp);
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 27; snk_idle_pct = 71; end
        1: begin src_idle_pct = 71; snk_idle_pct = 27; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        pick_item(op, d, p);
        offer(op, d, p, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d push, %0d pop, %0d read, %0d remove, %0d find, %0d clear items.",
             op_seen[idq_pkg::OP_PUSH_FRONT] + op_seen[idq_pkg::OP_PUSH_BACK],
             op_seen[idq_pkg::OP_POP_FRONT] + op_seen[idq_pkg::OP_POP_BACK],
             op_seen[idq_pkg::OP_READ], op_seen[idq_pkg::OP_REMOVE],
             op_seen[idq_pkg::OP_FIND], op_seen[idq_pkg::OP_CLEAR]);
    $display("Checked %0d results: %0d ok, %0d empty, %0d full, %0d range, %0d not found.",
             n_checked, status_seen[idq_pkg::ST_OK], status_seen[idq_pkg::ST_EMPTY],
             status_seen[idq_pkg::ST_FULL], status_seen[idq_pkg::ST_RANGE],
             status_seen[idq_pkg::ST_NOT_FOUND]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
